[design/at2op_pkg.sv]
// shared types, constants and the saturating q15 multiply for the arctan2 pipeline
// no dependencies; compile first
package at2op_pkg;

  localparam int DATA_W = 16;
  localparam int ROT_W = 3;
  localparam int OCT_STEP_SHIFT = 13;

  // dividend is |imag| << 15, so one quotient bit per step over its width
  localparam int DVD_W = 2 * DATA_W - 1;
  localparam int DIV_STEPS = DVD_W;

  localparam int POLY_TERMS = 5;

  // rotation steps, in units of pi/4
  localparam logic [ROT_W-1:0] ROT_NONE = 3'd0;
  localparam logic [ROT_W-1:0] ROT_OCT = 3'd1;
  localparam logic [ROT_W-1:0] ROT_QUAD = 3'd2;
  localparam logic [ROT_W-1:0] ROT_HALF = 3'd4;

  localparam logic signed [DATA_W-1:0] ANGLE_ZERO = 16'sh0000;
  localparam logic signed [DATA_W-1:0] ANGLE_NEG_PI = 16'sh8000;
  localparam logic signed [DATA_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] Q15_MIN = 16'sh8000;

  // horner coefficients, linear term first (the polynomial has no constant term)
  localparam logic signed [DATA_W-1:0] POLY_K [POLY_TERMS] = '{
    16'sh28BD, 16'sh006D, 16'shEF3E, 16'sh08C6, 16'shFED4
  };

  // side info that rides along with every word
  typedef struct packed {
    logic [ROT_W-1:0] rot;
    logic             spec;      // imaginary part was zero
    logic             spec_neg;  // and real part was negative
  } tag_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] im;
    logic signed [DATA_W-1:0] re;
    tag_t                     tag;
  } vec_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] q;
    tag_t                     tag;
  } quo_t;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DVD_W-1:0]  dq;
    logic [DATA_W-1:0] dvs;
    logic              neg;
    logic              zero;
    tag_t              tag;
  } div_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] q;
    tag_t                     tag;
  } poly_t;

  // q15 product with floor shift and saturation
  function automatic logic signed [DATA_W-1:0] qmul(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [2*DATA_W-1:0] p;
    logic signed [DATA_W:0]     s;
    p = (2*DATA_W)'(a) * (2*DATA_W)'(b);
    s = p[2*DATA_W-1:DATA_W-1];
    if (s > $signed({Q15_MAX[DATA_W-1], Q15_MAX})) begin
      return Q15_MAX;
    end else if (s < $signed({Q15_MIN[DATA_W-1], Q15_MIN})) begin
      return Q15_MIN;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

[design/at2op_if.sv]
// valid/ready stream interfaces for the vector input and the angle output
// no dependencies
interface at2op_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] imag_part;
  logic signed [15:0] real_part;

  modport source(output valid, output imag_part, output real_part, input ready);
  modport sink(input valid, input imag_part, input real_part, output ready);
endinterface

interface at2op_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;

  modport source(output valid, output angle, input ready);
  modport sink(input valid, input angle, output ready);
endinterface

[design/fixed_point_arctan2_octant_poly.sv]
// top level of the q15 four-quadrant arctangent pipeline
// depends on at2op_pkg, at2op_if, at2op_fold, at2op_div, at2op_poly
//
// channel  dir  handshake    word
// vec      in   valid/ready  imag_part, real_part (signed q1.15)
// result   out  valid/ready  angle (signed q1.15 fraction of pi)
//
// one word per clock sustained while the result side accepts; registers from accept to result:
// 2 fold stages, 33 divider stages (prep, 31 quotient bits, sign fixup),
// 5 horner multiply stages and the output register
// the divider's 31 quotient-bit stages, one bit per stage, set the depth
// rst is synchronous and clears only the stage valid bits
// each stage holds when its successor is full and stalled; empty stages
// keep filling, so ready drops only when every stage holds a word
module fixed_point_arctan2_octant_poly
  import at2op_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  at2op_in_if.sink     vec,
  at2op_out_if.source  result
);

  // fold -> divider
  logic fold_valid, fold_ready;
  vec_t fold_data;

  // divider -> polynomial
  logic quo_valid, quo_ready;
  quo_t quo_data;

  // rotate into the first octant
  at2op_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec.valid),
    .in_ready  (vec.ready),
    .imag_part (vec.imag_part),
    .real_part (vec.real_part),
    .out_valid (fold_valid),
    .out_ready (fold_ready),
    .out_data  (fold_data)
  );

  // tangent = (im << 15) / re, truncated toward zero, low 16 bits kept
  at2op_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fold_valid),
    .in_ready  (fold_ready),
    .in_data   (fold_data),
    .out_valid (quo_valid),
    .out_ready (quo_ready),
    .out_data  (quo_data)
  );

  // polynomial on the tangent plus the octant offset, zero-imag special case
  at2op_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quo_valid),
    .in_ready  (quo_ready),
    .in_data   (quo_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .angle     (result.angle)
  );

`ifndef SYNTHESIS
  // input can only back up when the whole pipe is full behind a stalled result
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !vec.ready |-> (result.valid && !result.ready))
    else $error("input stalled while output side can drain");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

[design/at2op_fold.sv]
// octant fold: two pipeline stages rotating the vector into the first octant
// depends on at2op_pkg
module at2op_fold
  import at2op_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] imag_part,
  input  logic signed [DATA_W-1:0] real_part,
  output logic                     out_valid,
  input  logic                     out_ready,
  output vec_t                     out_data
);

  logic v1, v2, en1, en2;
  vec_t s1, s2, s1_next, s2_next;
  logic signed [DATA_W-1:0] im_a, re_a;
  logic [ROT_W-1:0]         rot_a;
  logic signed [DATA_W:0]   sum2;
  logic signed [DATA_W-1:0] dif2;

  assign en2 = !v2 || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  // half and quadrant turn
  always_comb begin
    im_a  = imag_part;
    re_a  = real_part;
    rot_a = ROT_NONE;
    if (imag_part[DATA_W-1]) begin
      im_a  = -imag_part;
      re_a  = -real_part;
      rot_a = ROT_HALF;
    end
    s1_next.tag.spec     = (imag_part == ANGLE_ZERO);
    s1_next.tag.spec_neg = real_part[DATA_W-1];
    if (re_a <= $signed(ANGLE_ZERO)) begin
      s1_next.re      = im_a;
      s1_next.im      = -re_a;
      s1_next.tag.rot = rot_a + ROT_QUAD;
    end else begin
      s1_next.re      = re_a;
      s1_next.im      = im_a;
      s1_next.tag.rot = rot_a;
    end
  end

  assign sum2 = {s1.re[DATA_W-1], s1.re} + {s1.im[DATA_W-1], s1.im};
  assign dif2 = s1.im - s1.re;

  // octant turn, halving both when the sum overflows
  always_comb begin
    s2_next = s1;
    if (s1.re <= s1.im) begin
      s2_next.tag.rot = s1.tag.rot + ROT_OCT;
      if (sum2[DATA_W-1]) begin
        s2_next.re = sum2[DATA_W:1];
        s2_next.im = dif2 >>> 1;
      end else begin
        s2_next.re = sum2[DATA_W-1:0];
        s2_next.im = dif2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
  end

  assign out_valid = v2;
  assign out_data  = s2;

endmodule

[design/at2op_div.sv]
// pipelined restoring divider: one quotient bit per stage, truncates toward zero
// depends on at2op_pkg
module at2op_div
  import at2op_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  vec_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output quo_t out_data
);

  logic [DIV_STEPS:0]   v;
  logic [DIV_STEPS+1:0] en;
  div_t                 st [DIV_STEPS+1];
  div_t                 prep;
  logic                 vo;
  quo_t                 qo;
  logic [DATA_W-1:0]    mag_im, mag_re;

  function automatic div_t div_step(input div_t d);
    div_t             r;
    logic [DATA_W:0]  r2;
    logic [DATA_W:0]  diff;
    logic             ge;
    r    = d;
    r2   = {d.rem, d.dq[DVD_W-1]};
    diff = r2 - {1'b0, d.dvs};
    ge   = (r2 >= {1'b0, d.dvs});
    r.rem = ge ? diff[DATA_W-1:0] : r2[DATA_W-1:0];
    r.dq  = {d.dq[DVD_W-2:0], ge};
    return r;
  endfunction

  assign en[DIV_STEPS+1] = !vo || out_ready;
  assign in_ready = en[0];

  // magnitudes and sign of the quotient
  assign mag_im = in_data.im[DATA_W-1] ? -in_data.im : in_data.im;
  assign mag_re = in_data.re[DATA_W-1] ? -in_data.re : in_data.re;

  always_comb begin
    prep.rem  = '0;
    prep.dq   = {mag_im, {(DVD_W-DATA_W){1'b0}}};
    prep.dvs  = mag_re;
    prep.neg  = in_data.im[DATA_W-1] ^ in_data.re[DATA_W-1];
    prep.zero = (in_data.re == ANGLE_ZERO);
    prep.tag  = in_data.tag;
  end

  genvar i;
  generate
    for (i = 0; i <= DIV_STEPS; i++) begin : g_stage
      assign en[i] = !v[i] || en[i+1];
      if (i == 0) begin : g_prep
        always_ff @(posedge clk) begin
          if (rst) v[0] <= 1'b0;
          else if (en[0]) v[0] <= in_valid;
        end
        always_ff @(posedge clk) begin
          if (en[0]) st[0] <= prep;
        end
      end else begin : g_step
        always_ff @(posedge clk) begin
          if (rst) v[i] <= 1'b0;
          else if (en[i]) v[i] <= v[i-1];
        end
        always_ff @(posedge clk) begin
          if (en[i]) st[i] <= div_step(st[i-1]);
        end
      end
    end
  endgenerate

  // sign fixup, keep the low 16 bits; zero divisor gives zero
  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (en[DIV_STEPS+1]) vo <= v[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en[DIV_STEPS+1]) begin
      qo.tag <= st[DIV_STEPS].tag;
      if (st[DIV_STEPS].zero) qo.q <= ANGLE_ZERO;
      else if (st[DIV_STEPS].neg) qo.q <= -st[DIV_STEPS].dq[DATA_W-1:0];
      else qo.q <= st[DIV_STEPS].dq[DATA_W-1:0];
    end
  end

  assign out_valid = vo;
  assign out_data  = qo;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v[DIV_STEPS] && !st[DIV_STEPS].zero |-> st[DIV_STEPS].rem < st[DIV_STEPS].dvs)
    else $error("divider remainder not below divisor");
`endif

endmodule

[design/at2op_poly.sv]
// horner evaluation, one saturating q15 multiply per stage, then the octant offset
// depends on at2op_pkg
module at2op_poly
  import at2op_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  quo_t                     in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] angle
);

  logic [POLY_TERMS-1:0] v;
  logic [POLY_TERMS:0]   en;
  poly_t                 ps [POLY_TERMS];
  logic                  vo;
  logic signed [DATA_W-1:0] ang;
  poly_t                 last;

  assign en[POLY_TERMS] = !vo || out_ready;
  assign in_ready = en[0];

  genvar j;
  generate
    for (j = 0; j < POLY_TERMS; j++) begin : g_term
      logic signed [DATA_W-1:0] a_sum;
      assign en[j] = !v[j] || en[j+1];
      if (j == 0) begin : g_first
        assign a_sum = POLY_K[POLY_TERMS-1];
        always_ff @(posedge clk) begin
          if (rst) v[0] <= 1'b0;
          else if (en[0]) v[0] <= in_valid;
        end
        always_ff @(posedge clk) begin
          if (en[0]) begin
            ps[0].acc <= qmul(a_sum, in_data.q);
            ps[0].q   <= in_data.q;
            ps[0].tag <= in_data.tag;
          end
        end
      end else begin : g_next
        assign a_sum = ps[j-1].acc + POLY_K[POLY_TERMS-1-j];
        always_ff @(posedge clk) begin
          if (rst) v[j] <= 1'b0;
          else if (en[j]) v[j] <= v[j-1];
        end
        always_ff @(posedge clk) begin
          if (en[j]) begin
            ps[j].acc <= qmul(a_sum, ps[j-1].q);
            ps[j].q   <= ps[j-1].q;
            ps[j].tag <= ps[j-1].tag;
          end
        end
      end
    end
  endgenerate

  assign last = ps[POLY_TERMS-1];

  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (en[POLY_TERMS]) vo <= v[POLY_TERMS-1];
  end

  always_ff @(posedge clk) begin
    if (en[POLY_TERMS]) begin
      if (last.tag.spec) ang <= last.tag.spec_neg ? ANGLE_NEG_PI : ANGLE_ZERO;
      else ang <= last.acc + (DATA_W'(last.tag.rot) << OCT_STEP_SHIFT);
    end
  end

  assign out_valid = vo;
  assign angle     = ang;

endmodule
